// ----- hw/rtl/rebcp_pkg.sv -----
// Shared types, constants and constant tables for the rounded edge Bezier
// control point unit. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package rebcp_pkg;

    // Default number of fraction bits of every coordinate (Q1.16).
    localparam int DEF_FRAC_BITS = 16;

    // Curve constants are Q.30; a blend numerator always fits 32 bits.
    localparam int NUM_W   = 32;
    localparam int Q_SHIFT = 30;
    localparam int LANES   = 6;

    typedef logic [NUM_W-1:0] t_num;
    typedef t_num t_curve [4];
    typedef t_num t_num_tab [16];
    typedef t_num_tab t_lane_tabs [LANES];

    // Edge group codes: which axis the rounded edge runs along.
    localparam logic [1:0] GRP_X = 2'd0;
    localparam logic [1:0] GRP_Y = 2'd1;
    localparam logic [1:0] GRP_Z = 2'd2;

    // Reflection codes for the two cross coordinates.
    localparam logic [1:0] REFL_NONE  = 2'd0;
    localparam logic [1:0] REFL_ROT_A = 2'd1;
    localparam logic [1:0] REFL_ROT_B = 2'd2;
    localparam logic [1:0] REFL_BOTH  = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_EDGE   = 1'b0;
    localparam logic CFG_RADIUS = 1'b1;

    // Lane numbers: a and b parts of the first, second and third cell.
    localparam int LANE_FA = 0;
    localparam int LANE_FB = 1;
    localparam int LANE_SA = 2;
    localparam int LANE_SB = 3;
    localparam int LANE_TA = 4;
    localparam int LANE_TB = 5;

    // Decoded edge selection handed from the register block to the datapath.
    typedef struct packed {
        logic [1:0] grp;
        logic [1:0] refl;
    } t_edge_ctrl;

    // Converts a decimal fraction given in units of 1e-8 to Q.30, rounded.
    function automatic logic [63:0] q30_dec(input logic [63:0] d);
        return ((d << Q_SHIFT) + 64'd50000000) / 64'd100000000;
    endfunction

    localparam logic [63:0] Q30_ONE = 64'd1 << Q_SHIFT;
    localparam logic [63:0] Q_HALF  = Q30_ONE / 64'd2;
    localparam logic [63:0] Q_SIXTH = (Q30_ONE + 64'd3) / 64'd6;
    localparam logic [63:0] Q_THIRD = (64'd2 * Q30_ONE + 64'd3) / 64'd6;
    localparam logic [63:0] K_C1    = q30_dec(64'd26521647);
    localparam logic [63:0] K_C2    = q30_dec(64'd51957023);
    localparam logic [63:0] K_C3    = q30_dec(64'd89464307);
    localparam logic [63:0] K_C4    = q30_dec(64'd70710665);

    // Quarter-circle curves, indexed by the curve lattice index.
    localparam t_curve CRV_ZERO = '{t_num'(0), t_num'(0), t_num'(0), t_num'(0)};
    localparam t_curve CRV_A1X  = '{t_num'(0), t_num'(Q_SIXTH), t_num'(Q_THIRD),
                                    t_num'(Q_HALF)};
    localparam t_curve CRV_A1Y  = '{t_num'(Q_HALF), t_num'(Q_HALF), t_num'(Q_HALF),
                                    t_num'(Q_HALF)};
    localparam t_curve CRV_A2X  = '{t_num'(0), t_num'(K_C1), t_num'(K_C2),
                                    t_num'(K_C4)};
    localparam t_curve CRV_A2Y  = '{t_num'(Q30_ONE), t_num'(Q30_ONE), t_num'(K_C3),
                                    t_num'(K_C4)};
    localparam t_curve CRV_B1X  = '{t_num'(Q_HALF), t_num'(Q_HALF), t_num'(Q_HALF),
                                    t_num'(Q_HALF)};
    localparam t_curve CRV_B1Y  = '{t_num'(Q_HALF), t_num'(Q_THIRD), t_num'(Q_SIXTH),
                                    t_num'(0)};
    localparam t_curve CRV_B2X  = '{t_num'(K_C4), t_num'(K_C3), t_num'(Q30_ONE),
                                    t_num'(Q30_ONE)};
    localparam t_curve CRV_B2Y  = '{t_num'(K_C4), t_num'(K_C2), t_num'(K_C1),
                                    t_num'(0)};

    // Builds the blend numerator c1*(3-s) + c2*s for every {curve, blend} index.
    function automatic t_num_tab build_tab(input t_curve c1, input t_curve c2);
        t_num_tab    tab;
        logic [63:0] acc;
        for (int t = 0; t < 4; t++) begin
            for (int s = 0; s < 4; s++) begin
                acc = 64'(c1[t]) * 64'(3 - s) + 64'(c2[t]) * 64'(s);
                tab[t * 4 + s] = t_num'(acc);
            end
        end
        return tab;
    endfunction

    localparam t_lane_tabs LANE_TAB = '{
        build_tab(CRV_A1Y, CRV_A2Y),
        build_tab(CRV_A1X, CRV_A2X),
        build_tab(CRV_B1Y, CRV_B2Y),
        build_tab(CRV_B1X, CRV_B2X),
        build_tab(CRV_ZERO, CRV_A1Y),
        build_tab(CRV_A1X, CRV_A1X)
    };

endpackage

// ----- hw/rtl/rebcp_cfg.sv -----
// Configuration registers of the rounded edge Bezier unit: edge selection
// and radius, with edge decoding and radius clamping. Uses rebcp_pkg.
`timescale 1ns / 1ps

module rebcp_cfg #(
    parameter int FRAC_BITS = rebcp_pkg::DEF_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_index,
    input  logic [FRAC_BITS:0]    i_cfg_data,
    output rebcp_pkg::t_edge_ctrl o_ctrl,
    output logic [FRAC_BITS:0]    o_radius
);
    import rebcp_pkg::*;

    localparam int              FW  = FRAC_BITS + 1;
    localparam logic [FW-1:0]   ONE = FW'(1) << FRAC_BITS;

    logic [3:0]    r_edge;
    logic [3:0]    n_edge;
    logic [FW-1:0] r_radius;
    logic [FW-1:0] n_radius;
    logic          w_wr;

    // Always writable; the user must make writes only while the unit is idle.
    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid & o_cfg_ready;

    always_comb begin
        n_edge   = r_edge;
        n_radius = r_radius;
        if (w_wr) begin
            case (i_cfg_index)
                CFG_EDGE:   n_edge   = i_cfg_data[3:0];
                CFG_RADIUS: n_radius = i_cfg_data;
                default:    n_edge   = r_edge;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_edge   <= '0;
            r_radius <= ONE;
        end else begin
            r_edge   <= n_edge;
            r_radius <= n_radius;
        end
    end

    // The unused fourth group behaves as the x-axis group.
    always_comb begin
        o_ctrl.refl = r_edge[1:0];
        case (r_edge[3:2])
            GRP_Y:   o_ctrl.grp = GRP_Y;
            GRP_Z:   o_ctrl.grp = GRP_Z;
            default: o_ctrl.grp = GRP_X;
        endcase
    end

    // A radius above one is clamped so every coordinate stays within 0..1.
    assign o_radius = (r_radius > ONE) ? ONE : r_radius;

endmodule

// ----- hw/rtl/rebcp_blend.sv -----
// One blend lane: radius times a Q.30 numerator, divided by 3*2^30 with
// rounding, as a three-register pipeline. Uses rebcp_pkg.
`timescale 1ns / 1ps

module rebcp_blend #(
    parameter int FRAC_BITS = rebcp_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic [FRAC_BITS:0] i_radius,
    input  rebcp_pkg::t_num    i_num,
    output logic [FRAC_BITS:0] o_value
);
    import rebcp_pkg::*;

    localparam int            FW      = FRAC_BITS + 1;
    localparam int            PW      = FW + NUM_W;
    // The shifted quotient is at most 3*2^FRAC_BITS + 1.
    localparam int            QW      = FRAC_BITS + 2;
    localparam int            EW      = 2 * QW;
    localparam int            DIVISOR = 3;
    localparam logic [PW-1:0] RND     = PW'(64'd3 << (Q_SHIFT - 1));
    localparam logic [QW-1:0] RECIP   = QW'((64'd1 << QW) / 64'd3);

    logic [PW-1:0] r_prod;
    logic [QW-1:0] r_quo;
    logic [QW-1:0] r_quo_d;
    logic [EW-1:0] r_est_prod;
    logic [FW-1:0] w_est;
    logic [QW-1:0] w_three;
    logic [QW-1:0] w_rem;

    // Product, rounded shift by 30, then reciprocal multiply for the divide by 3.
    always_ff @(posedge i_clk) begin
        r_prod     <= PW'(i_radius) * PW'(i_num);
        r_quo      <= QW'((r_prod + RND) >> Q_SHIFT);
        r_est_prod <= EW'(r_quo) * EW'(RECIP);
        r_quo_d    <= r_quo;
    end

    // The estimate is low by at most one; the remainder fixes it.
    assign w_est   = FW'(r_est_prod >> QW);
    assign w_three = (QW'(w_est) << 1) + QW'(w_est);
    assign w_rem   = r_quo_d - w_three;
    assign o_value = w_est + FW'(w_rem >= QW'(DIVISOR));

endmodule

// ----- hw/rtl/rebcp_place.sv -----
// Placement of one cell's point: swaps, reflects and permutes the blended
// values and the step coordinate by edge. Uses rebcp_pkg.
`timescale 1ns / 1ps

module rebcp_place #(
    parameter int FRAC_BITS = rebcp_pkg::DEF_FRAC_BITS
) (
    input  rebcp_pkg::t_edge_ctrl i_ctrl,
    input  logic [FRAC_BITS:0]    i_step,
    input  logic [FRAC_BITS:0]    i_a,
    input  logic [FRAC_BITS:0]    i_b,
    output logic [FRAC_BITS:0]    o_x,
    output logic [FRAC_BITS:0]    o_y,
    output logic [FRAC_BITS:0]    o_z
);
    import rebcp_pkg::*;

    localparam int            FW  = FRAC_BITS + 1;
    localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

    logic [FW-1:0] w_a;
    logic [FW-1:0] w_b;
    logic [FW-1:0] w_p;
    logic [FW-1:0] w_q;

    // The y-axis group takes the curve parts the other way round.
    assign w_a = (i_ctrl.grp == GRP_Y) ? i_b : i_a;
    assign w_b = (i_ctrl.grp == GRP_Y) ? i_a : i_b;

    always_comb begin
        case (i_ctrl.refl)
            REFL_NONE: begin
                w_p = w_a;
                w_q = w_b;
            end
            REFL_ROT_A: begin
                w_p = w_b;
                w_q = ONE - w_a;
            end
            REFL_ROT_B: begin
                w_p = ONE - w_b;
                w_q = w_a;
            end
            default: begin
                w_p = ONE - w_a;
                w_q = ONE - w_b;
            end
        endcase
    end

    // The step coordinate goes on the edge axis, the cross pair on the others.
    always_comb begin
        case (i_ctrl.grp)
            GRP_Y: begin
                o_x = w_p;
                o_y = i_step;
                o_z = w_q;
            end
            GRP_Z: begin
                o_x = w_p;
                o_y = w_q;
                o_z = i_step;
            end
            default: begin
                o_x = i_step;
                o_y = w_p;
                o_z = w_q;
            end
        endcase
    end

endmodule

// ----- hw/rtl/rounded_edge_bezier_control_points_unit.sv -----
// Rounded edge Bezier control point unit (top level). Uses rebcp_pkg,
// rebcp_cfg, rebcp_blend and rebcp_place.
// Usage: a lattice index triple is taken at a clock edge with start high and
// busy low. busy is low whenever reset is released, so one beat can be taken
// in every cycle. Each beat passes the input register, the three-register
// blend lanes and the result register in that order; the nine coordinates
// of the first, second and third cell then stand on the result ports for one
// cycle with o_strobe high. A result is never held back since the receiver
// cannot stall. Throughput is one beat per cycle.
// The configuration channel (valid/ready, index, data) writes edge selection
// (index 0) or radius (index 1); it is always ready. It is to be written only
// while no beat is in flight, a rule the user must keep: the block itself
// does not enforce it. Synchronous reset selects edge 0, radius one, and
// drops every beat in flight.
`timescale 1ns / 1ps

module rounded_edge_bezier_control_points_unit #(
    parameter int FRAC_BITS = rebcp_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_lattice_i,
    input  logic [1:0]         i_lattice_j,
    input  logic [1:0]         i_lattice_k,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [FRAC_BITS:0] i_cfg_data,
    output logic               o_strobe,
    output logic [FRAC_BITS:0] o_first_x,
    output logic [FRAC_BITS:0] o_first_y,
    output logic [FRAC_BITS:0] o_first_z,
    output logic [FRAC_BITS:0] o_second_x,
    output logic [FRAC_BITS:0] o_second_y,
    output logic [FRAC_BITS:0] o_second_z,
    output logic [FRAC_BITS:0] o_third_x,
    output logic [FRAC_BITS:0] o_third_y,
    output logic [FRAC_BITS:0] o_third_z
);
    import rebcp_pkg::*;

    localparam int            FW    = FRAC_BITS + 1;
    localparam int            DEPTH = 4;
    localparam logic [FW-1:0] ONE   = FW'(1) << FRAC_BITS;
    localparam logic [FW-1:0] STEP1 = FW'(((1 << FRAC_BITS) + 1) / 3);
    localparam logic [FW-1:0] STEP2 = FW'(((2 << FRAC_BITS) + 1) / 3);

    t_edge_ctrl    w_ctrl;
    logic [FW-1:0] w_radius;
    logic          w_accept;
    logic [1:0]    w_t;
    logic [1:0]    w_s;
    logic [1:0]    w_st;
    logic [1:0]    r_t;
    logic [1:0]    r_s;
    logic [1:0]    r_st [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic          r_strobe;
    t_num          w_num [LANES];
    logic [FW-1:0] w_val [LANES];
    logic [FW-1:0] w_step;
    logic [FW-1:0] n_pt [3][3];
    logic [FW-1:0] r_pt [3][3];

    // Configuration registers.
    rebcp_cfg #(
        .FRAC_BITS (FRAC_BITS)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_ctrl      (w_ctrl),
        .o_radius    (w_radius)
    );

    assign busy     = ~i_rst_n;
    assign w_accept = start & ~busy;

    // Pick curve, blend and step indexes by edge group.
    always_comb begin
        case (w_ctrl.grp)
            GRP_Y: begin
                w_t  = i_lattice_i;
                w_s  = i_lattice_k;
                w_st = i_lattice_j;
            end
            GRP_Z: begin
                w_t  = i_lattice_j;
                w_s  = i_lattice_i;
                w_st = i_lattice_k;
            end
            default: begin
                w_t  = i_lattice_k;
                w_s  = i_lattice_j;
                w_st = i_lattice_i;
            end
        endcase
    end

    // Input register and the step index carried along the lanes.
    always_ff @(posedge i_clk) begin
        r_t     <= w_t;
        r_s     <= w_s;
        r_st[0] <= w_st;
        for (int i = 1; i < DEPTH; i++) begin
            r_st[i] <= r_st[i-1];
        end
    end

    // Beat tracking through the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_vld    <= {r_vld[DEPTH-2:0], w_accept};
            r_strobe <= r_vld[DEPTH-1];
        end
    end

    // Numerator lookup and one blend lane per cross value.
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        assign w_num[l] = LANE_TAB[l][{r_t, r_s}];

        rebcp_blend #(
            .FRAC_BITS (FRAC_BITS)
        ) u_blend (
            .i_clk    (i_clk),
            .i_radius (w_radius),
            .i_num    (w_num[l]),
            .o_value  (w_val[l])
        );
    end

    // Step coordinate along the edge axis.
    always_comb begin
        case (r_st[DEPTH-1])
            2'd0:    w_step = '0;
            2'd1:    w_step = STEP1;
            2'd2:    w_step = STEP2;
            default: w_step = ONE;
        endcase
    end

    // Placement of the three cell points.
    rebcp_place #(
        .FRAC_BITS (FRAC_BITS)
    ) u_place_first (
        .i_ctrl (w_ctrl),
        .i_step (w_step),
        .i_a    (w_val[LANE_FA]),
        .i_b    (w_val[LANE_FB]),
        .o_x    (n_pt[0][0]),
        .o_y    (n_pt[0][1]),
        .o_z    (n_pt[0][2])
    );

    rebcp_place #(
        .FRAC_BITS (FRAC_BITS)
    ) u_place_second (
        .i_ctrl (w_ctrl),
        .i_step (w_step),
        .i_a    (w_val[LANE_SA]),
        .i_b    (w_val[LANE_SB]),
        .o_x    (n_pt[1][0]),
        .o_y    (n_pt[1][1]),
        .o_z    (n_pt[1][2])
    );

    rebcp_place #(
        .FRAC_BITS (FRAC_BITS)
    ) u_place_third (
        .i_ctrl (w_ctrl),
        .i_step (w_step),
        .i_a    (w_val[LANE_TA]),
        .i_b    (w_val[LANE_TB]),
        .o_x    (n_pt[2][0]),
        .o_y    (n_pt[2][1]),
        .o_z    (n_pt[2][2])
    );

    // Result register, loaded when a beat leaves the lanes.
    always_ff @(posedge i_clk) begin
        if (r_vld[DEPTH-1]) begin
            r_pt <= n_pt;
        end
    end

    assign o_strobe   = r_strobe;
    assign o_first_x  = r_pt[0][0];
    assign o_first_y  = r_pt[0][1];
    assign o_first_z  = r_pt[0][2];
    assign o_second_x = r_pt[1][0];
    assign o_second_y = r_pt[1][1];
    assign o_second_z = r_pt[1][2];
    assign o_third_x  = r_pt[2][0];
    assign o_third_y  = r_pt[2][1];
    assign o_third_z  = r_pt[2][2];

`ifndef ASSERT_OFF
    // Every accepted beat produces a result.
    a_accept_to_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("accepted beat produced no result");

    // No result appears without an accepted beat.
    a_strobe_from_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 5))
        else $error("result without an accepted beat");

    // Every coordinate of a result stays within 0..1.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_first_x <= ONE && o_first_y <= ONE && o_first_z <= ONE &&
                      o_second_x <= ONE && o_second_y <= ONE && o_second_z <= ONE &&
                      o_third_x <= ONE && o_third_y <= ONE && o_third_z <= ONE))
        else $error("coordinate above one");
`endif

endmodule

// ----- dv/tb_rounded_edge_bezier_control_points_unit.sv -----
// Self-checking testbench for the rounded edge Bezier control point unit.
// Depends on rebcp_pkg and rounded_edge_bezier_control_points_unit; a small
// scoreboard class predicts the nine coordinates of every lattice beat.
`timescale 1ns / 1ps

module tb_rounded_edge_bezier_control_points_unit;

    import rebcp_pkg::*;

    localparam int FB           = DEF_FRAC_BITS;
    localparam int STALL_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = 10;
    localparam int PHASES       = 20;
    localparam int BEATS_PER_PH = 20;

    // Fixed-point constants of the quarter-circle curves, Q.30.
    localparam longint unsigned ONE_Q  = 64'd1 << FB;
    localparam longint unsigned Q30    = 64'd1 << 30;
    localparam longint unsigned HALF   = Q30 / 64'd2;
    localparam longint unsigned SIXTH  = (Q30 + 64'd3) / 64'd6;
    localparam longint unsigned THIRD  = (64'd2 * Q30 + 64'd3) / 64'd6;
    localparam longint unsigned ARC_1  = ((64'd26521647 << 30) + 64'd50000000) / 64'd100000000;
    localparam longint unsigned ARC_2  = ((64'd51957023 << 30) + 64'd50000000) / 64'd100000000;
    localparam longint unsigned ARC_3  = ((64'd89464307 << 30) + 64'd50000000) / 64'd100000000;
    localparam longint unsigned ARC_4  = ((64'd70710665 << 30) + 64'd50000000) / 64'd100000000;
    localparam longint unsigned BL_DEN = 64'd3 << 30;

    // Curve identifiers within the scoreboard's curve table.
    localparam int CV_A1X = 0;
    localparam int CV_A1Y = 1;
    localparam int CV_A2X = 2;
    localparam int CV_A2Y = 3;
    localparam int CV_B1X = 4;
    localparam int CV_B1Y = 5;
    localparam int CV_B2X = 6;
    localparam int CV_B2Y = 7;

    typedef logic [FB:0]      t_coord;
    typedef logic [2:0][FB:0] t_cell;
    typedef logic [8:0][FB:0] t_coord_set;

    // Predicts control points and holds the expected ones until they come out.
    class point_scoreboard;
        longint unsigned curve_tab[8][4];
        logic [3:0]      edge_sel;
        t_coord          radius_q;
        t_coord_set      expected_q[$];
        int unsigned     beats;
        int unsigned     results;
        int unsigned     reg_writes;
        int unsigned     mismatches;
        string           field_name[9] = '{"first_x", "first_y", "first_z",
                                           "second_x", "second_y", "second_z",
                                           "third_x", "third_y", "third_z"};

        function new();
            curve_tab[CV_A1X] = '{64'd0, SIXTH, THIRD, HALF};
            curve_tab[CV_A1Y] = '{HALF, HALF, HALF, HALF};
            curve_tab[CV_A2X] = '{64'd0, ARC_1, ARC_2, ARC_4};
            curve_tab[CV_A2Y] = '{Q30, Q30, ARC_3, ARC_4};
            curve_tab[CV_B1X] = '{HALF, HALF, HALF, HALF};
            curve_tab[CV_B1Y] = '{HALF, THIRD, SIXTH, 64'd0};
            curve_tab[CV_B2X] = '{ARC_4, ARC_3, Q30, Q30};
            curve_tab[CV_B2Y] = '{ARC_4, ARC_2, ARC_1, 64'd0};
            edge_sel   = 4'd0;
            radius_q   = t_coord'(ONE_Q);
            beats      = 0;
            results    = 0;
            reg_writes = 0;
            mismatches = 0;
        endfunction

        // Radius times the s/3 blend between two curve values, rounded.
        function longint unsigned blend_q(longint unsigned r, longint unsigned c1,
                                          longint unsigned c2, int unsigned s);
            longint unsigned num;
            num = c1 * longint'(3 - s) + c2 * longint'(s);
            return (r * num + BL_DEN / 2) / BL_DEN;
        endfunction

        // Maps the blended (a, b) pair onto the axes of the selected edge.
        function t_cell place_cell(logic [1:0] grp, logic [1:0] refl,
                                   longint unsigned step, longint unsigned a,
                                   longint unsigned b);
            longint unsigned p;
            longint unsigned q;
            longint unsigned tmp;
            t_cell           c;
            if (grp == GRP_Y) begin
                tmp = a;
                a   = b;
                b   = tmp;
            end
            case (refl)
                REFL_NONE: begin
                    p = a;
                    q = b;
                end
                REFL_ROT_A: begin
                    p = b;
                    q = ONE_Q - a;
                end
                REFL_ROT_B: begin
                    p = ONE_Q - b;
                    q = a;
                end
                default: begin
                    p = ONE_Q - a;
                    q = ONE_Q - b;
                end
            endcase
            if (grp == GRP_Y) begin
                c[0] = t_coord'(p);
                c[1] = t_coord'(step);
                c[2] = t_coord'(q);
            end else if (grp == GRP_Z) begin
                c[0] = t_coord'(p);
                c[1] = t_coord'(q);
                c[2] = t_coord'(step);
            end else begin
                c[0] = t_coord'(step);
                c[1] = t_coord'(p);
                c[2] = t_coord'(q);
            end
            return c;
        endfunction

        function t_coord_set predict_points(logic [1:0] li, logic [1:0] lj,
                                            logic [1:0] lk);
            logic [1:0]      grp;
            logic [1:0]      refl;
            int unsigned     t;
            int unsigned     s;
            int unsigned     st;
            longint unsigned r;
            longint unsigned step;
            t_cell           c_first;
            t_cell           c_second;
            t_cell           c_third;
            grp  = edge_sel[3:2];
            refl = edge_sel[1:0];
            r    = (radius_q > ONE_Q) ? ONE_Q : longint'(radius_q);
            // The unused group code behaves like the x axis group.
            if (grp == GRP_Y) begin
                t  = li;
                s  = lk;
                st = lj;
            end else if (grp == GRP_Z) begin
                t  = lj;
                s  = li;
                st = lk;
            end else begin
                grp = GRP_X;
                t   = lk;
                s   = lj;
                st  = li;
            end
            step = (longint'(st) * ONE_Q + 64'd1) / 64'd3;
            c_first = place_cell(grp, refl, step,
                blend_q(r, curve_tab[CV_A1Y][t], curve_tab[CV_A2Y][t], s),
                blend_q(r, curve_tab[CV_A1X][t], curve_tab[CV_A2X][t], s));
            c_second = place_cell(grp, refl, step,
                blend_q(r, curve_tab[CV_B1Y][t], curve_tab[CV_B2Y][t], s),
                blend_q(r, curve_tab[CV_B1X][t], curve_tab[CV_B2X][t], s));
            c_third = place_cell(grp, refl, step,
                blend_q(r, 64'd0, curve_tab[CV_A1Y][t], s),
                blend_q(r, curve_tab[CV_A1X][t], curve_tab[CV_A1X][t], s));
            return {c_third, c_second, c_first};
        endfunction

        function void write_reg(logic idx, t_coord data);
            if (idx == CFG_EDGE) begin
                edge_sel = data[3:0];
            end else begin
                radius_q = data;
            end
            reg_writes++;
        endfunction

        function void note_beat(logic [1:0] li, logic [1:0] lj, logic [1:0] lk);
            expected_q.push_back(predict_points(li, lj, lk));
            beats++;
        endfunction

        function void check_result(t_coord_set got);
            t_coord_set want;
            results++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR %0t: result with no lattice beat pending", $time);
                end
            end else begin
                want = expected_q.pop_front();
                for (int f = 0; f < 9; f++) begin
                    if (got[f] !== want[f]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("ERROR %0t: %s expected %0d got %0d (edge %0d radius %0d)",
                                     $time, field_name[f], want[f], got[f],
                                     edge_sel, radius_q);
                        end
                    end
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_lattice_i;
    logic [1:0] i_lattice_j;
    logic [1:0] i_lattice_k;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic       i_cfg_index;
    t_coord     i_cfg_data;
    logic       o_strobe;
    t_coord     o_first_x;
    t_coord     o_first_y;
    t_coord     o_first_z;
    t_coord     o_second_x;
    t_coord     o_second_y;
    t_coord     o_second_z;
    t_coord     o_third_x;
    t_coord     o_third_y;
    t_coord     o_third_z;

    point_scoreboard sb;
    int unsigned     stall_count = 0;
    bit              moved;
    bit [15:0]       edges_seen;

    rounded_edge_bezier_control_points_unit #(
        .FRAC_BITS (FB)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_lattice_i (i_lattice_i),
        .i_lattice_j (i_lattice_j),
        .i_lattice_k (i_lattice_k),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_first_x   (o_first_x),
        .o_first_y   (o_first_y),
        .o_first_z   (o_first_z),
        .o_second_x  (o_second_x),
        .o_second_y  (o_second_y),
        .o_second_z  (o_second_z),
        .o_third_x   (o_third_x),
        .o_third_y   (o_third_y),
        .o_third_z   (o_third_z)
    );

    // Clock with a 4 ns period.
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Monitor: results are checked before the beat taken at the same edge is
    // noted, and a watchdog ends the run when nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_strobe) begin
                sb.check_result({o_third_z, o_third_y, o_third_x,
                                 o_second_z, o_second_y, o_second_x,
                                 o_first_z, o_first_y, o_first_x});
                moved = 1'b1;
            end
            if (start && !busy) begin
                sb.note_beat(i_lattice_i, i_lattice_j, i_lattice_k);
                moved = 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
                moved = 1'b1;
            end
            if (moved) begin
                stall_count = 0;
            end else begin
                stall_count++;
            end
            if (stall_count >= STALL_LIMIT) begin
                $display("Watchdog expired with %0d results outstanding", sb.pending());
                $display("** rounded_edge_bezier_control_points_unit: FAILED **");
                $finish;
            end
        end
    end

    // Drives one lattice beat and returns at the edge that accepts it;
    // start stays high so the caller can chain the next beat.
    task automatic send_beat(logic [1:0] li, logic [1:0] lj, logic [1:0] lk);
        start       <= 1'b1;
        i_lattice_i <= li;
        i_lattice_j <= lj;
        i_lattice_k <= lk;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic idle_sender(int unsigned cycles);
        if (cycles > 0) begin
            start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Random beats in bursts of random length, with gaps that are sometimes
    // zero so that long back-to-back stretches occur too.
    task automatic send_random(int unsigned count);
        int unsigned left;
        int unsigned burst;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 16);
            if (burst > left) burst = left;
            repeat (burst) begin
                send_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                          2'($urandom_range(0, 3)));
            end
            left -= burst;
            idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
        end
    endtask

    // Holds off the sender until every expected result has come out, then
    // lets the pipeline settle.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_config(logic [3:0] edge_val, t_coord radius_val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_EDGE;
        i_cfg_data  <= t_coord'(edge_val);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_index <= CFG_RADIUS;
        i_cfg_data  <= radius_val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        edges_seen[edge_val] = 1'b1;
    endtask

    initial begin
        logic [3:0] edge_val;
        t_coord     radius_val;
        sb          = new();
        edges_seen  = '0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_lattice_i = 2'd0;
        i_lattice_j = 2'd0;
        i_lattice_k = 2'd0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_EDGE;
        i_cfg_data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the reset setting: five corners and every index value.
        edges_seen[0] = 1'b1;
        send_beat(2'd0, 2'd0, 2'd0);
        send_beat(2'd3, 2'd3, 2'd3);
        send_beat(2'd3, 2'd0, 2'd0);
        send_beat(2'd0, 2'd3, 2'd0);
        send_beat(2'd0, 2'd0, 2'd3);
        send_beat(2'd1, 2'd2, 2'd3);
        send_beat(2'd3, 2'd2, 2'd1);
        send_beat(2'd2, 2'd1, 2'd0);
        send_beat(2'd1, 2'd1, 2'd1);
        send_beat(2'd2, 2'd2, 2'd2);
        drain();

        // Every edge code, including the aliased ones, with radii from zero
        // through one to values that must clamp.
        for (int ph = 0; ph < PHASES; ph++) begin
            edge_val = (ph < 16) ? 4'(ph) : 4'($urandom_range(0, 15));
            case (ph % 5)
                0: radius_val = t_coord'(ONE_Q);
                1: radius_val = '0;
                2: radius_val = '1;
                3: radius_val = t_coord'($urandom_range(32'(ONE_Q + 1),
                                                        32'(2 * ONE_Q - 1)));
                default: radius_val = t_coord'($urandom_range(1, 32'(ONE_Q - 1)));
            endcase
            write_config(edge_val, radius_val);
            send_beat(2'd0, 2'd0, 2'd0);
            send_beat(2'd3, 2'd3, 2'd3);
            send_random(BEATS_PER_PH);
            drain();
        end

        $display("Covered %0d lattice beats and %0d results over %0d register writes,",
                 sb.beats, sb.results, sb.reg_writes);
        $display("with %0d of 16 edge codes and radii of zero, one, fractions and clamped.",
                 $countones(edges_seen));
        if (sb.pending() > 0) begin
            $display("ERROR: %0d expected results never came out", sb.pending());
        end
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("** rounded_edge_bezier_control_points_unit: PASSED **");
        end else begin
            $display("Mismatches: %0d", sb.mismatches);
            $display("** rounded_edge_bezier_control_points_unit: FAILED **");
        end
        $finish;
    end

endmodule
